// ----- sv/qsl_pkg.sv -----
package qsl_pkg;
  localparam int MaxItems = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int StackDepth = 64;
  localparam int SpW = 7;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // write in_value at load_idx
    idx_t load_idx;
    logic rd_en;       // read element at rd_idx
    idx_t rd_idx;
    logic wr_en;       // write selected register at wr_idx
    idx_t wr_idx;
    logic wr_sel_b;    // 0: write reg a, 1: write reg b
    logic wr_sel_piv;  // write pivot register, overrides wr_sel_b
    logic cap_a;       // capture read data into a
    logic cap_b;       // capture read data into b
    logic cap_piv;     // capture read data into pivot
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic le;          // a <= pivot, signed
    logic [31:0] rd_data;
  } dp_sts_t;
endpackage

// ----- sv/qsl_if.sv -----
interface qsl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        last;
  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface qsl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_value;
  logic        last_out;
  logic        overflow;
  modport source (output valid, sorted_value, last_out, overflow, input ready);
  modport sink (input valid, sorted_value, last_out, overflow, output ready);
endinterface

// ----- sv/qsl_datapath.sv -----
module qsl_datapath
  import qsl_pkg::*;
(
  input  logic        clk,
  input  dp_cmd_t     cmd,
  input  logic [31:0] in_value,
  output dp_sts_t     sts
);
  logic [31:0] mem [MaxItems];
  logic [31:0] rd_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] piv_r;

  // element store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[cmd.load_idx] <= in_value;
    end else if (cmd.wr_en) begin
      mem[cmd.wr_idx] <= cmd.wr_sel_piv ? piv_r : (cmd.wr_sel_b ? b_r : a_r);
    end
    if (cmd.rd_en) begin
      rd_r <= mem[cmd.rd_idx];
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_r <= rd_r;
    end
    if (cmd.cap_b) begin
      b_r <= rd_r;
    end
    if (cmd.cap_piv) begin
      piv_r <= rd_r;
    end
  end

  assign sts.le = $signed(a_r) <= $signed(piv_r);
  assign sts.rd_data = rd_r;
endmodule

// ----- sv/qsl_ctrl.sv -----
module qsl_ctrl
  import qsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic        out_last,
  output logic        out_ovf,
  output dp_cmd_t     cmd,
  input  dp_sts_t     sts
);
  typedef enum logic [3:0] {
    S_LOAD, S_POP, S_PIV, S_PIVW, S_RDJ, S_RDJW, S_CMP, S_RDI, S_RDIW, S_SWW,
    S_FIN, S_FINW, S_PUSH, S_ERD, S_EWAIT, S_EOUT
  } state_t;

  state_t state_r, state_nxt;
  cnt_t cnt_r, cnt_nxt;
  logic drop_r, drop_nxt;
  logic [2*IdxW-1:0] stk_r [StackDepth];
  logic [SpW-1:0] sp_r, sp_nxt;
  idx_t lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  logic swp_r, swp_nxt;
  logic push_en;
  logic pop_en;
  logic [2*IdxW-1:0] push_data;
  logic [2*IdxW-1:0] top_r;
  cnt_t last_idx;
  logic [31:0] ov_r, ov_nxt;
  logic ol_r, ol_nxt, oo_r, oo_nxt, ovld_r, ovld_nxt;

  assign last_idx = cnt_r - 1'b1;

  // range stack, registered read of the top entry on pop
  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_r[sp_r[IdxW-1:0]] <= push_data;
    end
    if (pop_en) begin
      top_r <= stk_r[sp_r[IdxW-1:0] - 1'b1];
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    drop_nxt = drop_r;
    sp_nxt = sp_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    i_nxt = i_r;
    j_nxt = j_r;
    swp_nxt = swp_r;
    ov_nxt = ov_r;
    ol_nxt = ol_r;
    oo_nxt = oo_r;
    ovld_nxt = ovld_r;
    push_en = 1'b0;
    pop_en = 1'b0;
    push_data = '0;
    cmd = '0;
    in_ready = (state_r == S_LOAD);
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < cnt_t'(MaxItems)) begin
            cmd.load = 1'b1;
            cmd.load_idx = cnt_r[IdxW-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            sp_nxt = '0;
            if (cnt_nxt >= cnt_t'(2)) begin
              push_en = 1'b1;
              push_data = {idx_t'(0), idx_t'(cnt_nxt - 1'b1)};
              sp_nxt = SpW'(1);
            end
            i_nxt = '0;
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          i_nxt = '0;
          state_nxt = S_ERD;
        end else begin
          sp_nxt = sp_r - 1'b1;
          pop_en = 1'b1;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        lo_nxt = top_r[2*IdxW-1:IdxW];
        hi_nxt = top_r[IdxW-1:0];
        cmd.rd_en = 1'b1;
        cmd.rd_idx = top_r[IdxW-1:0];
        i_nxt = top_r[2*IdxW-1:IdxW];
        j_nxt = top_r[2*IdxW-1:IdxW];
        state_nxt = S_PIVW;
      end
      S_PIVW: begin
        cmd.cap_piv = 1'b1;
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        if (j_r == hi_r) begin
          cmd.rd_en = 1'b1;
          cmd.rd_idx = i_r;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_idx = j_r;
          state_nxt = S_RDJW;
        end
      end
      S_RDJW: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.le) begin
          cmd.rd_en = 1'b1;
          cmd.rd_idx = i_r;
          state_nxt = S_RDIW;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_RDJ;
        end
      end
      S_RDIW: begin
        // a holds elem[j], b takes elem[i]; swap them
        cmd.cap_b = 1'b1;
        state_nxt = S_SWW;
      end
      S_SWW: begin
        if (!swp_r) begin
          cmd.wr_en = 1'b1;
          cmd.wr_idx = i_r;
          swp_nxt = 1'b1;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wr_idx = j_r;
          cmd.wr_sel_b = 1'b1;
          swp_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
          j_nxt = j_r + 1'b1;
          state_nxt = S_RDJ;
        end
      end
      S_FIN: begin
        // pivot into slot i, elem[i] into slot hi
        cmd.cap_b = 1'b1;
        state_nxt = S_FINW;
      end
      S_FINW: begin
        if (!swp_r) begin
          cmd.wr_en = 1'b1;
          cmd.wr_idx = hi_r;
          cmd.wr_sel_b = 1'b1;
          swp_nxt = 1'b1;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wr_idx = i_r;
          cmd.wr_sel_piv = 1'b1;
          swp_nxt = 1'b0;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!swp_r) begin
          if (i_r < hi_r && (i_r + 1'b1) < hi_r) begin
            push_en = 1'b1;
            push_data = {idx_t'(i_r + 1'b1), hi_r};
            sp_nxt = sp_r + 1'b1;
          end
          swp_nxt = 1'b1;
        end else begin
          if (i_r > lo_r && lo_r < idx_t'(i_r - 1'b1)) begin
            push_en = 1'b1;
            push_data = {lo_r, idx_t'(i_r - 1'b1)};
            sp_nxt = sp_r + 1'b1;
          end
          swp_nxt = 1'b0;
          state_nxt = S_POP;
        end
      end
      S_ERD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_idx = i_r;
        state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt = 1'b1;
          ov_nxt = sts.rd_data;
          ol_nxt = (cnt_t'(i_r) == last_idx);
          oo_nxt = drop_r;
          if (cnt_t'(i_r) == last_idx) begin
            cnt_nxt = '0;
            drop_nxt = 1'b0;
            sp_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      drop_r <= 1'b0;
      sp_r <= '0;
      swp_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      drop_r <= drop_nxt;
      sp_r <= sp_nxt;
      swp_r <= swp_nxt;
      ovld_r <= ovld_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    ov_r <= ov_nxt;
    ol_r <= ol_nxt;
    oo_r <= oo_nxt;
  end

  assign out_valid = ovld_r;
  assign out_value = ov_r;
  assign out_last = ol_r;
  assign out_ovf = oo_r;
endmodule

// ----- sv/quicksort_lomuto.sv -----
// quicksort with lomuto partition over up to 64 signed 32-bit elements
// input channel: one element per beat, one beat per cycle while loading;
//   the beat with last high ends the set and starts the sort
// beats beyond 64 in a set are dropped and flag overflow on every result
// sorting: per range the pivot is read, then each element is read and compared
//   with it and swapped when not greater, paced by the one read and one write port
//   of the element store; worst case order n^2 comparisons
// output: after the sort ends, elements are read from the store in order
//   into the output register, one beat at a time, last_out on the final one
// a stalled receiver holds the current beat in the output register; input
//   is not taken again until the final beat of the set is in that register
// reset (synchronous, active low) clears the element count and drops pending output
module quicksort_lomuto
  import qsl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  qsl_in_if.sink    in_ch,
  qsl_out_if.source out_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  qsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.sorted_value),
    .out_last  (out_ch.last_out),
    .out_ovf   (out_ch.overflow),
    .cmd       (cmd),
    .sts       (sts)
  );

  // element store and compare
  qsl_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_value (in_ch.value),
    .sts      (sts)
  );

  // write and load never collide
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd.load && cmd.wr_en))
    else $error("load and swap write together");
  // a stalled result stays valid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && cmd.rd_en))
    else $error("read during load");
endmodule

// ----- tb/tb_quicksort_lomuto.sv -----
`timescale 1ns / 1ps

module tb_quicksort_lomuto
  import qsl_pkg::*;
;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } elem_beat_t;

  typedef struct packed {
    logic [31:0] sorted_value;
    logic        last_out;
    logic        overflow;
  } sorted_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qsl_in_if  in_ch ();
  qsl_out_if out_ch ();

  quicksort_lomuto DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  elem_beat_t   pending_elems[$];
  sorted_beat_t expected_sorted[$];

  // predictor state: the current set of elements
  logic [31:0] set_elems[$];
  logic        set_dropped = 1'b0;

  int errors = 0;
  int sets_done = 0;
  int beats_seen = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  bit stim_done = 1'b0;

  // accept one element; on last, sort the set and queue the results
  task automatic predict_elem(input elem_beat_t b);
    logic [31:0] sorted[$];
    logic [31:0] t;
    int n;
    if (set_elems.size() < MaxItems) set_elems.insert(set_elems.size(), b.value);
    else set_dropped = 1'b1;
    if (b.last) begin
      sorted = set_elems;
      n = sorted.size();
      // simple insertion sort, signed compare
      for (int i = 1; i < n; i++) begin
        for (int j = i; j > 0 && $signed(sorted[j-1]) > $signed(sorted[j]); j--) begin
          t = sorted[j];
          sorted[j] = sorted[j-1];
          sorted[j-1] = t;
        end
      end
      for (int k = 0; k < n; k++)
        expected_sorted.insert(expected_sorted.size(), '{sorted[k], k == n - 1, set_dropped});
      set_elems.delete();
      set_dropped = 1'b0;
      sets_done++;
    end
  endtask

  function automatic logic [31:0] rand_value(input int mode);
    case (mode % 5)
      0: rand_value = $urandom_range(0, 15);
      1: rand_value = 32'h8000_0000 + $urandom_range(0, 3);
      2: rand_value = 32'h7fff_fffc + $urandom_range(0, 3);
      3: rand_value = $urandom;
      default: rand_value = -$urandom_range(0, 15);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_ch.last  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_elem('{in_ch.value, in_ch.last});
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_elems.size() > 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
          in_ch.valid <= 1'b1;
          {in_ch.value, in_ch.last} <= pending_elems.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    sorted_beat_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(0, 99) >= 36;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sorted_value, out_ch.last_out, out_ch.overflow};
        beats_seen++;
        if (expected_sorted.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h", $time, got);
        end else begin
          want = expected_sorted.pop_front();
          if (got.sorted_value !== want.sorted_value) begin
            errors++;
            $display("%0t: sorted_value exp %h got %h", $time, want.sorted_value,
                     got.sorted_value);
          end
          if (got.last_out !== want.last_out) begin
            errors++;
            $display("%0t: last_out exp %b got %b", $time, want.last_out, got.last_out);
          end
          if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow exp %b got %b", $time, want.overflow, got.overflow);
          end
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_set(input int n, input int mode);
    for (int i = 0; i < n; i++)
      pending_elems.insert(pending_elems.size(), '{rand_value(mode + i), i == n - 1});
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single element, extremes, duplicates, sorted and reversed
    pending_elems.insert(pending_elems.size(), '{32'h8000_0000, 1'b1});
    pending_elems.insert(pending_elems.size(), '{32'h7fff_ffff, 1'b0});
    pending_elems.insert(pending_elems.size(), '{32'h8000_0000, 1'b0});
    pending_elems.insert(pending_elems.size(), '{32'hffff_ffff, 1'b0});
    pending_elems.insert(pending_elems.size(), '{32'h0000_0000, 1'b0});
    pending_elems.insert(pending_elems.size(), '{32'h7fff_ffff, 1'b1});
    for (int i = 0; i < 5; i++) pending_elems.insert(pending_elems.size(), '{i, i == 4});
    for (int i = 5; i > 0; i--) pending_elems.insert(pending_elems.size(), '{i - 3, i == 1});
    pending_elems.insert(pending_elems.size(), '{32'd7, 1'b0});
    pending_elems.insert(pending_elems.size(), '{32'd7, 1'b0});
    pending_elems.insert(pending_elems.size(), '{32'd7, 1'b1});

    // full store, then overflow with last dropped
    add_set(MaxItems, 3);
    add_set(MaxItems + 3, 0);

    // random sets
    while (pending_elems.size() < 260) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
      add_set(n, $urandom_range(0, 4));
    end

    // a stretch with no idling in the middle of the run
    wait (pending_elems.size() < 160);
    no_idle = 1'b1;
    wait (pending_elems.size() < 100);
    no_idle = 1'b0;

    wait (pending_elems.size() == 0 && !in_ch.valid);
    no_idle = 1'b0;
    wait (expected_sorted.size() == 0);
    repeat (200) @(posedge clk);
    $display("sorted %0d sets, %0d result beats checked, incl. overflow sets",
             sets_done, beats_seen);
    if (errors == 0 && expected_sorted.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/qsl_pkg.sv
sv/qsl_if.sv
sv/qsl_datapath.sv
sv/qsl_ctrl.sv
sv/quicksort_lomuto.sv
tb/tb_quicksort_lomuto.sv
